// ===== rtl/pfu_pkg.sv =====
// pfu_pkg: widths, limits and the controller/datapath interface types of the
// prime factorizer. No dependencies; every other file of the block imports it.
package pfu_pkg;

  localparam int VALUE_BITS  = 16;
  localparam int IN_BITS     = 16;
  localparam int PRIME_BITS  = 16;
  localparam int EXP_BITS    = 12;
  localparam int IDX_BITS    = 3;
  localparam int SCALE_BITS  = 8;
  localparam int MAX_RESULTS = 6;

  // trial divisors never pass sqrt of the largest value plus one
  localparam int DIV_BITS  = VALUE_BITS / 2 + 1;
  localparam int MULT_BITS = $clog2(VALUE_BITS + 1);
  localparam int PROD_BITS = MULT_BITS + SCALE_BITS;
  localparam int STEP_BITS = $clog2(VALUE_BITS + 1);

  localparam logic [EXP_BITS-1:0]   EXP_MAX       = '1;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET   = SCALE_BITS'(1);
  localparam logic [DIV_BITS-1:0]   FIRST_DIVISOR = DIV_BITS'(2);

  typedef struct packed {
    logic load;
    logic div_start;
    logic take_quot;
    logic step_d;
    logic emit_fac;
    logic emit_rem;
  } pfu_cmd_t;

  typedef struct packed {
    logic in_small;
    logic loop_ok;
    logic rem_ok;
    logic div_done;
    logic rem_zero;
    logic mult_nz;
    logic out_free;
  } pfu_status_t;

endpackage

// ===== rtl/pfu_div.sv =====
// pfu_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on pfu_pkg for the dividend and divisor widths.
module pfu_div
  import pfu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0]   divisor,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIV_BITS-1:0]   remainder,
  output logic                  done
);

  logic [DIV_BITS-1:0]   acc;
  logic [VALUE_BITS-1:0] quo;
  logic [STEP_BITS-1:0]  cnt;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;
  logic                  fits;
  logic [DIV_BITS-1:0]   acc_next;

  assign trial = {acc, quo[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};
  // when the divisor does not fit, trial is below it and its top bit is zero
  assign acc_next = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= STEP_BITS'(VALUE_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - STEP_BITS'(1);
        if (cnt == STEP_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      quo <= dividend;
    end else if (cnt != '0) begin
      acc <= acc_next;
      quo <= {quo[VALUE_BITS-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = acc;

endmodule

// ===== rtl/pfu_dp.sv =====
// pfu_dp: datapath of the factorizer - residue, trial divisor, multiplicity,
// run count, power register, divider and output register. Uses pfu_pkg, pfu_div.
module pfu_dp
  import pfu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  pfu_cmd_t              cmd,
  output pfu_status_t           status,
  input  logic [IN_BITS-1:0]    value,
  input  logic                  cfg_en,
  input  logic [SCALE_BITS-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [PRIME_BITS-1:0] prime,
  output logic [EXP_BITS-1:0]   exponent,
  output logic [IDX_BITS-1:0]   factor_index,
  output logic                  last
);

  logic [VALUE_BITS-1:0]   n;
  logic [DIV_BITS-1:0]     d;
  logic [IDX_BITS-1:0]     count;
  logic [MULT_BITS-1:0]    mult;
  logic [SCALE_BITS-1:0]   power_scale;

  logic [VALUE_BITS-1:0]   value_in;
  logic [2*DIV_BITS-1:0]   dsq;
  logic [2*DIV_BITS-1:0]   n_ext;
  logic                    count_ok;
  logic [VALUE_BITS-1:0]   quotient;
  logic [DIV_BITS-1:0]     remainder;
  logic                    div_done;

  logic [MULT_BITS-1:0]    mult_sel;
  logic [PROD_BITS-1:0]    prod;
  logic [PROD_BITS-1:0]    scaled;
  logic [EXP_BITS-1:0]     exp_sat;
  logic [PRIME_BITS-1:0]   prime_sel;
  logic                    last_sel;
  logic                    emit;

  pfu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (n),
    .divisor   (d),
    .quotient  (quotient),
    .remainder (remainder),
    .done      (div_done)
  );

  assign value_in = VALUE_BITS'(value);
  assign dsq      = d * d;
  assign n_ext    = (2*DIV_BITS)'(n);
  assign count_ok = count < IDX_BITS'(MAX_RESULTS);

  assign status.in_small = value_in <= VALUE_BITS'(1);
  assign status.loop_ok  = (dsq <= n_ext) && count_ok;
  assign status.rem_ok   = (n > VALUE_BITS'(1)) && count_ok;
  assign status.div_done = div_done;
  assign status.rem_zero = remainder == '0;
  assign status.mult_nz  = mult != '0;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n     <= value_in;
      d     <= FIRST_DIVISOR;
      count <= '0;
      mult  <= '0;
    end else begin
      if (cmd.take_quot) begin
        n    <= quotient;
        mult <= mult + MULT_BITS'(1);
      end
      if (cmd.step_d) begin
        d <= d + DIV_BITS'(1);
      end
      if (cmd.emit_fac) begin
        d     <= d + DIV_BITS'(1);
        mult  <= '0;
        count <= count + IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_scale <= SCALE_RESET;
    end else if (cfg_en) begin
      power_scale <= cfg_data;
    end
  end

  // a leftover residue above one is always a single prime
  assign mult_sel  = cmd.emit_rem ? MULT_BITS'(1) : mult;
  assign prod      = mult_sel * power_scale;
  assign scaled    = (power_scale > SCALE_BITS'(1)) ? prod : PROD_BITS'(mult_sel);
  assign exp_sat   = (scaled > PROD_BITS'(EXP_MAX)) ? EXP_MAX : scaled[EXP_BITS-1:0];
  assign prime_sel = cmd.emit_rem ? PRIME_BITS'(n) : PRIME_BITS'(d);
  // leftover residue, residue down to one, or the run is full: nothing follows this factor
  assign last_sel  = cmd.emit_rem || (n == VALUE_BITS'(1)) ||
                     (count == IDX_BITS'(MAX_RESULTS - 1));
  assign emit      = cmd.emit_fac || cmd.emit_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      prime        <= prime_sel;
      exponent     <= exp_sat;
      factor_index <= count;
      last         <= last_sel;
    end
  end

endmodule

// ===== rtl/pfu_ctrl.sv =====
// pfu_ctrl: sequencer of the trial-division loop; drives datapath commands
// from datapath status. Uses pfu_pkg for the command and status structs.
module pfu_ctrl
  import pfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  pfu_status_t status,
  output pfu_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TEST  = 6'b000010,
    S_START = 6'b000100,
    S_DIV   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_LAST  = 6'b100000
  } pfu_state_t;

  pfu_state_t state;
  pfu_state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_small ? S_IDLE : S_TEST;
        end
      end
      S_TEST: begin
        if (status.loop_ok) begin
          state_next = S_START;
        end else if (status.rem_ok) begin
          state_next = S_LAST;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            // divides evenly: keep the quotient and try the same divisor again
            cmd.take_quot = 1'b1;
            state_next    = S_START;
          end else if (status.mult_nz) begin
            state_next = S_EMIT;
          end else begin
            cmd.step_d = 1'b1;
            state_next = S_TEST;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_fac = 1'b1;
          state_next   = S_TEST;
        end
      end
      S_LAST: begin
        if (status.out_free) begin
          cmd.emit_rem = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/prime_factorizer_unit.sv =====
// prime_factorizer_unit: top level of the trial-division prime factorizer.
// Joins pfu_ctrl and pfu_dp; uses pfu_pkg.
//
// Input channel: in_valid/in_ready carry one value per beat. The block takes
// a value only while idle and works on one value at a time.
// Output channel: out_valid/out_ready carry one beat per distinct prime factor,
// ascending, with its exponent (scaled by power_scale when above one, capped at
// 4095), its factor_index from 0 and last set on the final beat of the run.
// A value of 0 or 1 gives no beats and the block is ready again the next cycle.
// Timing: every trial divisor from 2 up to sqrt of the residue costs one
// pass of the bit-serial divider plus the S_TEST and S_START sequencing;
// each repeated division by a found factor costs another S_START and divider
// pass, each result an S_EMIT or S_LAST step. A 16-bit prime near 65535 takes
// longest, as every divisor up to its root is tried. The shared divider sets the pace.
// Output register: the block keeps working while a finished beat waits; when
// the receiver stalls with a beat still held, it waits at the next result.
// Configuration: cfg_en writes cfg_data into power_scale at once; write only
// while idle. Reset (rst, synchronous) sets power_scale to 1 and drops
// out_valid; in_ready is high from the first cycle after reset.
module prime_factorizer_unit
  import pfu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [IN_BITS-1:0]    value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PRIME_BITS-1:0] prime,
  output logic [EXP_BITS-1:0]   exponent,
  output logic [IDX_BITS-1:0]   factor_index,
  output logic                  last,
  input  logic                  cfg_en,
  input  logic [SCALE_BITS-1:0] cfg_data
);

  pfu_cmd_t    cmd;
  pfu_status_t status;

  pfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pfu_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .cfg_en       (cfg_en),
    .cfg_data     (cfg_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .prime        (prime),
    .exponent     (exponent),
    .factor_index (factor_index),
    .last         (last)
  );

endmodule

// ===== rtl/pfu_checker.sv =====
// pfu_checker: port-level assertions for prime_factorizer_unit, with the bind
// that attaches them. Uses pfu_pkg for the port widths.
module pfu_checker
  import pfu_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [IN_BITS-1:0]    value,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PRIME_BITS-1:0] prime,
  input logic [EXP_BITS-1:0]   exponent,
  input logic [IDX_BITS-1:0]   factor_index,
  input logic                  last
);

  // a held beat stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prime) && $stable(exponent) &&
      $stable(factor_index) && $stable(last))
    else $error("output beat changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // a value above one makes the block busy after it is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (value > IN_BITS'(1)) |=> !in_ready)
    else $error("input taken again while factoring");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (prime >= PRIME_BITS'(2)) && (exponent != '0) &&
      (factor_index < IDX_BITS'(MAX_RESULTS)))
    else $error("output beat fields out of range");

endmodule

bind prime_factorizer_unit pfu_checker u_pfu_checker (.*);
